>>> rtl/tpa_pkg.sv
// Shared types and constants for triangle primitive assembly.
package tpa_pkg;

   localparam int unsigned FIELD_BITS = 32;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      MODE_LIST  = 2'd0,
      MODE_STRIP = 2'd1,
      MODE_FAN   = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE   = 1'b0,
      CSR_VCOUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      mode_type              mode;
      logic [FIELD_BITS-1:0] vertex_count;
   } cfg_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] corner_a;
      logic [FIELD_BITS-1:0] corner_b;
      logic [FIELD_BITS-1:0] corner_c;
      logic                  has_triangle;
      logic                  run_done;
      status_type            run_status;
   } result_type;

endpackage

>>> rtl/tpa_req_if.sv
// Index channel: one vertex index per beat with a last-of-run mark.
interface tpa_req_if;
   import tpa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] index_value;
   logic                  run_last;

   modport source (output valid, output index_value, output run_last, input ready);
   modport sink   (input valid, input index_value, input run_last, output ready);
endinterface

>>> rtl/tpa_rsp_if.sv
// Result channel: one triangle and/or run close per beat.
interface tpa_rsp_if;
   import tpa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] corner_a;
   logic [FIELD_BITS-1:0] corner_b;
   logic [FIELD_BITS-1:0] corner_c;
   logic                  has_triangle;
   logic                  run_done;
   logic [1:0]            run_status;

   modport source (output valid, output corner_a, output corner_b, output corner_c,
                   output has_triangle, output run_done, output run_status, input ready);
   modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                   input has_triangle, input run_done, input run_status, output ready);
endinterface

>>> rtl/tpa_csr.sv
// Configuration registers: assembly mode and vertex count.
module tpa_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tpa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tpa_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output tpa_pkg::cfg_type                     cfg
);
   import tpa_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:   cfg_in.mode = mode_type'(csr_data[1:0]);
            CSR_VCOUNT: cfg_in.vertex_count = csr_data[FIELD_BITS-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: MODE_LIST, vertex_count: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> rtl/tpa_core.sv
// Run state and per-index triangle assembly logic.
module tpa_core #(
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             beat,
   input  logic [tpa_pkg::FIELD_BITS-1:0]   index_value,
   input  logic                             run_last,
   input  tpa_pkg::cfg_type                 cfg,
   output logic                             produce,
   output tpa_pkg::result_type              result
);
   import tpa_pkg::*;

   logic [INDEX_BITS-1:0] first_ff, first_in;
   logic [INDEX_BITS-1:0] older_ff, older_in;
   logic [INDEX_BITS-1:0] newer_ff, newer_in;
   logic [1:0]            pos3_ff, pos3_in;
   logic                  odd_ff, odd_in;
   logic [1:0]            seen_ff, seen_in;
   logic                  error_ff, error_in;

   logic [INDEX_BITS-1:0] idx;
   logic                  surface;
   logic                  err_now;
   logic                  ok;
   logic                  tri_hit;
   logic [INDEX_BITS-1:0] ca, cb;
   logic [1:0]            pos3_next;
   logic [1:0]            seen_next;
   logic                  short_run;

   assign idx     = index_value[INDEX_BITS-1:0];
   assign surface = cfg.mode != MODE_NONE;
   assign err_now = error_ff | (surface && (FIELD_BITS'(idx) >= cfg.vertex_count));
   assign ok      = surface && !err_now;

   always_comb begin
      tri_hit = 1'b0;
      ca      = older_ff;
      cb      = newer_ff;
      unique case (cfg.mode)
         MODE_LIST:  tri_hit = ok && (pos3_ff == 2'd2);
         MODE_STRIP: begin
            tri_hit = ok && (seen_ff >= 2'd2);
            if (odd_ff) begin
               ca = newer_ff;
               cb = older_ff;
            end
         end
         MODE_FAN: begin
            tri_hit = ok && (seen_ff >= 2'd2);
            ca      = first_ff;
         end
         default: tri_hit = 1'b0;
      endcase
   end

   assign pos3_next = (pos3_ff >= 2'd2) ? 2'd0 : pos3_ff + 2'd1;
   assign seen_next = (seen_ff == 2'd3) ? 2'd3 : seen_ff + 2'd1;
   assign short_run = (cfg.mode == MODE_LIST) ? (pos3_next != 2'd0) : (seen_next != 2'd3);

   always_comb begin
      first_in = first_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      pos3_in  = pos3_ff;
      odd_in   = odd_ff;
      seen_in  = seen_ff;
      error_in = error_ff;
      if (beat) begin
         if (seen_ff == 2'd0) begin
            first_in = idx;
         end
         if (cfg.mode == MODE_LIST) begin
            if (pos3_ff == 2'd0) begin
               older_in = idx;
            end else if (pos3_ff == 2'd1) begin
               newer_in = idx;
            end
         end else begin
            older_in = newer_ff;
            newer_in = idx;
         end
         pos3_in  = pos3_next;
         odd_in   = ~odd_ff;
         seen_in  = seen_next;
         error_in = err_now;
         if (run_last) begin
            first_in = '0;
            older_in = '0;
            newer_in = '0;
            pos3_in  = 2'd0;
            odd_in   = 1'b0;
            seen_in  = 2'd0;
            error_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         older_ff <= '0;
         newer_ff <= '0;
         pos3_ff  <= 2'd0;
         odd_ff   <= 1'b0;
         seen_ff  <= 2'd0;
         error_ff <= 1'b0;
      end else begin
         first_ff <= first_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
         pos3_ff  <= pos3_in;
         odd_ff   <= odd_in;
         seen_ff  <= seen_in;
         error_ff <= error_in;
      end
   end

   always_comb begin
      result              = '0;
      result.run_status   = STATUS_OK;
      result.has_triangle = tri_hit;
      result.run_done     = run_last;
      if (tri_hit) begin
         result.corner_a = FIELD_BITS'(ca);
         result.corner_b = FIELD_BITS'(cb);
         result.corner_c = FIELD_BITS'(idx);
      end
      if (run_last && surface) begin
         if (short_run) begin
            result.run_status = STATUS_SHORT;
         end else if (err_now) begin
            result.run_status = STATUS_RANGE;
         end
      end
   end

   assign produce = tri_hit | run_last;
endmodule

>>> rtl/tpa_out_reg.sv
// Result register between the assembly logic and the result channel.
module tpa_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tpa_pkg::result_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tpa_pkg::result_type  out_data
);
   import tpa_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

>>> rtl/triangle_primitive_assembly_top.sv
// Top level of triangle primitive assembly: config, assembly logic, result register.
//
//   channel  dir  beat payload
//   req      in   index_value, run_last
//   rsp      out  corner_a/b/c, has_triangle, run_done, run_status
//   csr      in   csr_we, csr_index, csr_data (write only)
//
// One index beat per cycle while req.ready is high; its result (if any) is shown the next cycle from the
// result register. req.ready drops only while the result register holds an untaken
// beat and rsp.ready is low. Synchronous reset clears run state, config and valid.
// Indices that close no triangle and no run make no result beat.
module triangle_primitive_assembly_top #(
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tpa_req_if.sink                              req,
   tpa_rsp_if.source                            rsp,
   input  logic                                 csr_we,
   input  logic [tpa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tpa_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import tpa_pkg::*;

   cfg_type    cfg;
   logic       beat;
   logic       produce;
   logic       in_ready;
   result_type core_result;
   result_type out_result;

   tpa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req.ready = in_ready;
   assign beat      = req.valid && in_ready;

   tpa_core #(
      .INDEX_BITS (INDEX_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .index_value (req.index_value),
      .run_last    (req.run_last),
      .cfg         (cfg),
      .produce     (produce),
      .result      (core_result)
   );

   tpa_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (beat && produce),
      .in_ready  (in_ready),
      .in_data   (core_result),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_result)
   );

   assign rsp.corner_a     = out_result.corner_a;
   assign rsp.corner_b     = out_result.corner_b;
   assign rsp.corner_c     = out_result.corner_c;
   assign rsp.has_triangle = out_result.has_triangle;
   assign rsp.run_done     = out_result.run_done;
   assign rsp.run_status   = out_result.run_status;
endmodule

>>> verif/tpa_assembly_checker.sv
// Checker for triangle primitive assembly: predicts triangles and run closes, compares beats.
module tpa_assembly_checker #(
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tpa_req_if                                   req_mon,
   tpa_rsp_if                                   rsp_mon,
   input  logic                                 csr_we,
   input  logic [tpa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tpa_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output int                                   error_count,
   output int                                   in_flight
);
   import tpa_pkg::*;

   localparam logic [FIELD_BITS-1:0] INDEX_MASK = FIELD_BITS'((64'd1 << INDEX_BITS) - 1);

   mode_type              cfg_mode;
   logic [FIELD_BITS-1:0] cfg_vcount;

   logic [FIELD_BITS-1:0] fan_root;
   logic [FIELD_BITS-1:0] older_corner;
   logic [FIELD_BITS-1:0] newer_corner;
   logic [1:0]            list_phase;
   logic                  strip_odd;
   logic [1:0]            seen_sat;
   logic                  range_fault;

   result_type            prims_due[$];
   int                    rsp_beats;

   initial begin
      error_count = 0;
      in_flight   = 0;
      rsp_beats   = 0;
   end

   task automatic clear_run();
      fan_root     = '0;
      older_corner = '0;
      newer_corner = '0;
      list_phase   = 2'd0;
      strip_odd    = 1'b0;
      seen_sat     = 2'd0;
      range_fault  = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [FIELD_BITS-1:0] got,
                                  input logic [FIELD_BITS-1:0] want);
      $display("ERROR: rsp beat %0d %s: got %h, expected %h", rsp_beats, what, got, want);
      error_count++;
   endtask

   // Advances the assembly state by one index and queues the beat it causes, if any.
   task automatic assemble_index(input logic [FIELD_BITS-1:0] raw, input logic last);
      logic [FIELD_BITS-1:0] idx;
      logic                  surface;
      logic                  emit_ok;
      result_type            prim;
      idx     = raw & INDEX_MASK;
      surface = cfg_mode != MODE_NONE;
      prim    = '0;
      if (surface && idx >= cfg_vcount) range_fault = 1'b1;
      emit_ok = surface && !range_fault;
      case (cfg_mode)
         MODE_LIST: begin
            if (emit_ok && list_phase == 2'd2) begin
               prim.has_triangle = 1'b1;
               prim.corner_a = older_corner;
               prim.corner_b = newer_corner;
               prim.corner_c = idx;
            end
         end
         MODE_STRIP: begin
            if (emit_ok && seen_sat >= 2'd2) begin
               prim.has_triangle = 1'b1;
               prim.corner_a = strip_odd ? newer_corner : older_corner;
               prim.corner_b = strip_odd ? older_corner : newer_corner;
               prim.corner_c = idx;
            end
         end
         MODE_FAN: begin
            if (emit_ok && seen_sat >= 2'd2) begin
               prim.has_triangle = 1'b1;
               prim.corner_a = fan_root;
               prim.corner_b = newer_corner;
               prim.corner_c = idx;
            end
         end
         default: ;
      endcase

      if (seen_sat == 2'd0) fan_root = idx;
      if (cfg_mode == MODE_LIST) begin
         if (list_phase == 2'd0) older_corner = idx;
         else if (list_phase == 2'd1) newer_corner = idx;
      end else begin
         older_corner = newer_corner;
         newer_corner = idx;
      end
      list_phase = (list_phase >= 2'd2) ? 2'd0 : list_phase + 2'd1;
      strip_odd  = ~strip_odd;
      if (seen_sat < 2'd3) seen_sat = seen_sat + 2'd1;

      if (last) begin
         prim.run_done = 1'b1;
         if (!surface) prim.run_status = STATUS_OK;
         else if (cfg_mode == MODE_LIST ? list_phase != 2'd0 : seen_sat < 2'd3)
            prim.run_status = STATUS_SHORT;
         else if (range_fault) prim.run_status = STATUS_RANGE;
         else prim.run_status = STATUS_OK;
         clear_run();
      end

      if (prim.has_triangle || prim.run_done) prims_due.insert(prims_due.size(), prim);
   endtask

   task automatic check_beat();
      result_type got;
      result_type want;
      got.corner_a     = rsp_mon.corner_a;
      got.corner_b     = rsp_mon.corner_b;
      got.corner_c     = rsp_mon.corner_c;
      got.has_triangle = rsp_mon.has_triangle;
      got.run_done     = rsp_mon.run_done;
      got.run_status   = status_type'(rsp_mon.run_status);
      if (prims_due.size() == 0) begin
         report_mismatch("unexpected beat, run_done", FIELD_BITS'(got.run_done), '0);
      end else begin
         want = prims_due.pop_front();
         if (got.corner_a !== want.corner_a)
            report_mismatch("corner_a", got.corner_a, want.corner_a);
         if (got.corner_b !== want.corner_b)
            report_mismatch("corner_b", got.corner_b, want.corner_b);
         if (got.corner_c !== want.corner_c)
            report_mismatch("corner_c", got.corner_c, want.corner_c);
         if (got.has_triangle !== want.has_triangle)
            report_mismatch("has_triangle", FIELD_BITS'(got.has_triangle),
                            FIELD_BITS'(want.has_triangle));
         if (got.run_done !== want.run_done)
            report_mismatch("run_done", FIELD_BITS'(got.run_done), FIELD_BITS'(want.run_done));
         if (got.run_status !== want.run_status)
            report_mismatch("run_status", FIELD_BITS'(got.run_status),
                            FIELD_BITS'(want.run_status));
      end
      rsp_beats++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_mode   = MODE_LIST;
         cfg_vcount = '0;
         clear_run();
         prims_due.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) check_beat();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            assemble_index(req_mon.index_value, req_mon.run_last);
         if (csr_we === 1'b1) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:   cfg_mode = mode_type'(csr_data[1:0]);
               CSR_VCOUNT: cfg_vcount = csr_data;
               default: ;
            endcase
         end
      end
      in_flight <= prims_due.size();
   end

endmodule

>>> verif/tb_triangle_primitive_assembly_top.sv
// Testbench top for triangle primitive assembly: clock, reset, index runs, config and verdict.
module tb_triangle_primitive_assembly_top;
   import tpa_pkg::*;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_data;

   int                         fail_count;
   int                         in_flight;
   int                         send_idle_pct;
   int                         stall_pct;
   mode_type                   cur_mode;
   logic [FIELD_BITS-1:0]      cur_vcount;

   tpa_req_if req_ch ();
   tpa_rsp_if rsp_ch ();

   triangle_primitive_assembly_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tpa_assembly_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (fail_count),
      .in_flight   (in_flight)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #4800000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_index(input logic [FIELD_BITS-1:0] value, input logic last);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.index_value <= value;
      req_ch.run_last    <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Waits until every expected beat is back, then lets the result register settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [CSR_DATA_BITS-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (which == CSR_MODE) cur_mode = mode_type'(value[1:0]);
      else cur_vcount = value;
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_index();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (cur_vcount == '0 || roll < 8) return $urandom();
      if (roll < 14) return cur_vcount + FIELD_BITS'($urandom_range(0, 3));
      if (roll < 20) return cur_vcount - 1;
      return $urandom_range(0, cur_vcount - 1);
   endfunction

   function automatic logic [FIELD_BITS-1:0] pick_vcount();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 25) return '1;
      if (roll < 40) return $urandom();
      return $urandom_range(1, 64);
   endfunction

   task automatic send_run(inout int sent);
      int len;
      if ($urandom_range(0, 99) < 80)
         len = (cur_mode == MODE_LIST) ? 3 * $urandom_range(1, 4) : $urandom_range(3, 12);
      else
         len = $urandom_range(1, 5);
      for (int i = 1; i <= len; i++) send_index(pick_index(), i == len);
      sent += len;
   endtask

   initial begin
      int sent;
      int send_by_phase[4];
      int stall_by_phase[4];
      send_by_phase  = '{0, 62, 0, 36};
      stall_by_phase = '{0, 0, 62, 36};
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.index_value = '0;
      req_ch.run_last    = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_MODE;
      csr_data           = '0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      cur_mode           = MODE_LIST;
      cur_vcount         = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed runs
      write_reg(CSR_VCOUNT, 32'd8);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_LIST));
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd7, 1'b1);
      send_index(32'd5, 1'b0);
      send_index(32'd6, 1'b1);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_STRIP));
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd3, 1'b1);
      send_index(32'd1, 1'b0);
      send_index(32'd9, 1'b0);
      send_index(32'd2, 1'b1);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_FAN));
      send_index(32'd4, 1'b0);
      send_index(32'd5, 1'b1);
      send_index(32'd9, 1'b1);
      // mode change in the middle of a run
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_LIST));
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_STRIP));
      send_index(32'd3, 1'b1);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_NONE));
      send_index(32'hFFFF_FFFF, 1'b0);
      send_index(32'd0, 1'b1);
      write_reg(CSR_VCOUNT, 32'hFFFF_FFFF);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_LIST));
      send_index(32'hFFFF_FFFE, 1'b0);
      send_index(32'd0, 1'b0);
      send_index(32'hFFFF_FFFF, 1'b1);
      write_reg(CSR_VCOUNT, 32'd0);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_FAN));
      send_index(32'd0, 1'b0);
      send_index(32'd0, 1'b0);
      send_index(32'd0, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_by_phase[ph];
         stall_pct     = stall_by_phase[ph];
         sent = 0;
         while (sent < 150) begin
            write_reg(CSR_MODE, $urandom_range(0, 3));
            write_reg(CSR_VCOUNT, pick_vcount());
            repeat ($urandom_range(2, 5)) send_run(sent);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
rtl/tpa_pkg.sv
rtl/tpa_req_if.sv
rtl/tpa_rsp_if.sv
rtl/tpa_csr.sv
rtl/tpa_core.sv
rtl/tpa_out_reg.sv
rtl/triangle_primitive_assembly_top.sv
verif/tpa_assembly_checker.sv
verif/tb_triangle_primitive_assembly_top.sv
